### rtl/core/hsv2rgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
`default_nettype none
package hsv2rgb_pkg;

    // Hue resolution: 2^HUE_BITS steps per turn.
    localparam int HUE_BITS = 16;
    // Fraction bits of the Q1.F levels; 2^LEVEL_FRAC_BITS is 1.0.
    localparam int LEVEL_FRAC_BITS = 15;

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int HUE6_W = HUE_BITS + 3;
    localparam int SECTOR_W = 3;
    localparam int BYTE_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CMP_W = (CFG_DATA_W > LEVEL_W) ? CFG_DATA_W : LEVEL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

    localparam logic [CFG_DATA_W-1:0] SATURATION_RESET = 16'd23593;
    localparam logic [CFG_DATA_W-1:0] BRIGHTNESS_RESET = 16'd32768;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'd1;

    // Hue sectors, each one sixth of a turn.
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;

    typedef logic [LEVEL_W-1:0] level_t;

    // Saturates a register value to 1.0.
    function automatic level_t level_clamp(input logic [CFG_DATA_W-1:0] x);
        logic [CMP_W-1:0] xw;
        logic [CMP_W-1:0] onew;
        xw = CMP_W'(x);
        onew = CMP_W'(LEVEL_ONE);
        if (xw > onew)
            return LEVEL_ONE;
        else
            return xw[LEVEL_W-1:0];
    endfunction

    // Computes floor(channel * 255) for a Q1.F level of at most 1.0.
    function automatic logic [BYTE_W-1:0] to_byte(input level_t c);
        logic [LEVEL_W+BYTE_W-1:0] prod;
        prod = ({c, {BYTE_W{1'b0}}}) - (LEVEL_W+BYTE_W)'(c);
        return prod[LEVEL_FRAC_BITS +: BYTE_W];
    endfunction

endpackage
`default_nettype wire

### rtl/core/hsv_to_rgb_converter.sv
// HSV to RGB converter: four-stage pipeline from hue to an 8-bit RGB triple.
`default_nettype none
// Each hue beat (an unsigned fraction of a turn) becomes one red/green/blue
// beat at the saturation and brightness held in configuration registers 0 and
// 1 (Q1.15, values above 1.0 are treated as 1.0). The pipeline takes one beat
// per clock while hue_stall is low; the four register stages are the sector
// split, the saturation products, the brightness products, and the channel
// select with scaling to 0..255. A stall on the output holds the pipeline only
// as far back as it has no empty slot. Write the configuration only while no
// beat is in flight.
module hsv_to_rgb_converter
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [hsv2rgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hsv2rgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                                 hue_valid,
    output logic                                      hue_stall,
    input  wire logic [hsv2rgb_pkg::HUE_BITS-1:0]     hue_turns,
    output logic                                      rgb_valid,
    input  wire logic                                 rgb_stall,
    output logic [hsv2rgb_pkg::BYTE_W-1:0]            red,
    output logic [hsv2rgb_pkg::BYTE_W-1:0]            green,
    output logic [hsv2rgb_pkg::BYTE_W-1:0]            blue
);

    localparam int F = hsv2rgb_pkg::LEVEL_FRAC_BITS;
    localparam int LW = hsv2rgb_pkg::LEVEL_W;
    localparam int HB = hsv2rgb_pkg::HUE_BITS;
    localparam int SW = hsv2rgb_pkg::SECTOR_W;
    localparam int BW = hsv2rgb_pkg::BYTE_W;
    localparam int H6W = hsv2rgb_pkg::HUE6_W;

    // Configuration registers.
    logic [hsv2rgb_pkg::CFG_DATA_W-1:0] sat_reg;
    logic [hsv2rgb_pkg::CFG_DATA_W-1:0] bright_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= hsv2rgb_pkg::SATURATION_RESET;
            bright_reg <= hsv2rgb_pkg::BRIGHTNESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hsv2rgb_pkg::CFG_SATURATION: sat_reg <= cfg_data;
                hsv2rgb_pkg::CFG_BRIGHTNESS: bright_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hsv2rgb_pkg::level_t sat_lvl;
    hsv2rgb_pkg::level_t bright_lvl;

    assign sat_lvl = hsv2rgb_pkg::level_clamp(sat_reg);
    assign bright_lvl = hsv2rgb_pkg::level_clamp(bright_reg);

    // Pipeline valid bits and advance enables.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_adv, s2_adv, s3_adv, out_adv;

    assign out_adv = !out_valid_reg || !rgb_stall;
    assign s3_adv = !s3_valid_reg || out_adv;
    assign s2_adv = !s2_valid_reg || s3_adv;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign hue_stall = !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= hue_valid;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (s3_adv)
                s3_valid_reg <= s2_valid_reg;
            if (out_adv)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: hue times six, split into sector and fraction within it.
    logic [H6W-1:0]                 hue6;
    logic [HB+F-1:0]                frac_wide;
    logic [SW-1:0]                  s1_sector_next, s1_sector_reg;
    logic [F-1:0]                   s1_f_next, s1_f_reg;

    always_comb
    begin
        hue6 = H6W'({hue_turns, 2'b00}) + H6W'({hue_turns, 1'b0});
        s1_sector_next = hue6[HB +: SW];
        // Realigns the fraction from HUE_BITS to F fraction bits by truncation.
        frac_wide = {hue6[HB-1:0], {F{1'b0}}} >> HB;
        s1_f_next = frac_wide[F-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_sector_reg <= s1_sector_next;
            s1_f_reg <= s1_f_next;
        end
    end

    // Stage 2: saturation products for q and t, and the complement for p.
    logic [2*LW-1:0]         sf_prod, sfc_prod;
    hsv2rgb_pkg::level_t     f_comp;
    hsv2rgb_pkg::level_t     s2_qk_next, s2_qk_reg;
    hsv2rgb_pkg::level_t     s2_tk_next, s2_tk_reg;
    hsv2rgb_pkg::level_t     s2_pk_next, s2_pk_reg;
    logic [SW-1:0]           s2_sector_reg;

    always_comb
    begin
        f_comp = hsv2rgb_pkg::LEVEL_ONE - LW'(s1_f_reg);
        sf_prod = (2*LW)'(sat_lvl) * (2*LW)'(s1_f_reg);
        sfc_prod = (2*LW)'(sat_lvl) * (2*LW)'(f_comp);
        s2_qk_next = hsv2rgb_pkg::LEVEL_ONE - sf_prod[F +: LW];
        s2_tk_next = hsv2rgb_pkg::LEVEL_ONE - sfc_prod[F +: LW];
        s2_pk_next = hsv2rgb_pkg::LEVEL_ONE - sat_lvl;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_qk_reg <= s2_qk_next;
            s2_tk_reg <= s2_tk_next;
            s2_pk_reg <= s2_pk_next;
        end
    end

    // Stage 3: scale the three levels by brightness.
    logic [2*LW-1:0]     p_prod, q_prod, t_prod;
    hsv2rgb_pkg::level_t s3_p_reg, s3_q_reg, s3_t_reg, s3_v_reg;
    logic [SW-1:0]       s3_sector_reg;

    always_comb
    begin
        p_prod = (2*LW)'(bright_lvl) * (2*LW)'(s2_pk_reg);
        q_prod = (2*LW)'(bright_lvl) * (2*LW)'(s2_qk_reg);
        t_prod = (2*LW)'(bright_lvl) * (2*LW)'(s2_tk_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_p_reg <= p_prod[F +: LW];
            s3_q_reg <= q_prod[F +: LW];
            s3_t_reg <= t_prod[F +: LW];
            s3_v_reg <= bright_lvl;
        end
    end

    // Stage 4: six-sector channel select and scaling to a byte.
    hsv2rgb_pkg::level_t r_lvl, g_lvl, b_lvl;
    logic [BW-1:0]       red_next, green_next, blue_next;
    logic [BW-1:0]       red_reg, green_reg, blue_reg;

    always_comb
    begin
        case (s3_sector_reg)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:
            begin
                r_lvl = s3_v_reg; g_lvl = s3_t_reg; b_lvl = s3_p_reg;
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                r_lvl = s3_q_reg; g_lvl = s3_v_reg; b_lvl = s3_p_reg;
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:
            begin
                r_lvl = s3_p_reg; g_lvl = s3_v_reg; b_lvl = s3_t_reg;
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:
            begin
                r_lvl = s3_p_reg; g_lvl = s3_q_reg; b_lvl = s3_v_reg;
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                r_lvl = s3_t_reg; g_lvl = s3_p_reg; b_lvl = s3_v_reg;
            end
            default:
            begin
                r_lvl = s3_v_reg; g_lvl = s3_p_reg; b_lvl = s3_q_reg;
            end
        endcase
        red_next = hsv2rgb_pkg::to_byte(r_lvl);
        green_next = hsv2rgb_pkg::to_byte(g_lvl);
        blue_next = hsv2rgb_pkg::to_byte(b_lvl);
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            red_reg <= red_next;
            green_reg <= green_next;
            blue_reg <= blue_next;
        end
    end

    assign rgb_valid = out_valid_reg;
    assign red = red_reg;
    assign green = green_reg;
    assign blue = blue_reg;

endmodule
`default_nettype wire

### verif/hsv_to_rgb_converter_test.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
module hsv_to_rgb_converter_test;
    import hsv2rgb_pkg::*;

    typedef struct packed
    {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 64;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SATURATION;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic hue_valid = 1'b0;
    logic hue_stall;
    logic [HUE_BITS-1:0] hue_turns = '0;
    logic rgb_valid;
    logic rgb_stall = 1'b0;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;

    // Register copies as the block should hold them.
    logic [CFG_DATA_W-1:0] sat_level = SATURATION_RESET;
    logic [CFG_DATA_W-1:0] bright_level = BRIGHTNESS_RESET;

    logic [HUE_BITS-1:0] hue_pending [$];
    rgb_t rgb_awaited [$];

    bit idle_on = 1'b1;
    bit hold_done = 1'b0;
    int unsigned hue_gap = 0;
    int unsigned stall_left = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    logic [HUE_BITS-1:0] corner_hues [14] = '{
        16'd0, 16'd65535, 16'h5555, 16'hAAAA,
        16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
        16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614
    };

    hsv_to_rgb_converter i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .hue_valid(hue_valid),
        .hue_stall(hue_stall),
        .hue_turns(hue_turns),
        .rgb_valid(rgb_valid),
        .rgb_stall(rgb_stall),
        .red(red),
        .green(green),
        .blue(blue)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] scale_byte(input logic [47:0] chan);
        logic [47:0] wide;
        wide = (chan * 48'd255) >> LEVEL_FRAC_BITS;
        return wide[BYTE_W-1:0];
    endfunction

    function automatic rgb_t expected_rgb(input logic [HUE_BITS-1:0] hue,
                                          input logic [CFG_DATA_W-1:0] sat_reg,
                                          input logic [CFG_DATA_W-1:0] val_reg);
        logic [47:0] one;
        logic [47:0] s;
        logic [47:0] v;
        logic [47:0] h6;
        logic [47:0] f;
        logic [47:0] p;
        logic [47:0] q;
        logic [47:0] t;
        logic [47:0] r;
        logic [47:0] g;
        logic [47:0] b;
        logic [SECTOR_W-1:0] sector;
        rgb_t res;
        one = 48'd1 << LEVEL_FRAC_BITS;
        s = (48'(sat_reg) > one) ? one : 48'(sat_reg);
        v = (48'(val_reg) > one) ? one : 48'(val_reg);
        h6 = 48'(hue) * 48'd6;
        sector = SECTOR_W'(h6 >> HUE_BITS);
        // Realign the in-sector fraction from hue bits to level bits.
        f = ((h6 & ((48'd1 << HUE_BITS) - 48'd1)) << LEVEL_FRAC_BITS) >> HUE_BITS;
        if (f > one)
            f = one;
        p = (v * (one - s)) >> LEVEL_FRAC_BITS;
        q = (v * (one - ((s * f) >> LEVEL_FRAC_BITS))) >> LEVEL_FRAC_BITS;
        t = (v * (one - ((s * (one - f)) >> LEVEL_FRAC_BITS))) >> LEVEL_FRAC_BITS;
        case (sector)
            SECTOR_RED_YELLOW:
            begin
                r = v; g = t; b = p;
            end
            SECTOR_YELLOW_GREEN:
            begin
                r = q; g = v; b = p;
            end
            SECTOR_GREEN_CYAN:
            begin
                r = p; g = v; b = t;
            end
            SECTOR_CYAN_BLUE:
            begin
                r = p; g = q; b = v;
            end
            SECTOR_BLUE_MAGENTA:
            begin
                r = t; g = p; b = v;
            end
            default:
            begin
                r = v; g = p; b = q;
            end
        endcase
        res.red = scale_byte(r);
        res.green = scale_byte(g);
        res.blue = scale_byte(b);
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'(LEVEL_ONE);
            2: return CFG_DATA_W'($urandom_range(32'(LEVEL_ONE) + 1, 65535));
            default: return CFG_DATA_W'($urandom_range(0, 32'(LEVEL_ONE)));
        endcase
    endfunction

    function automatic logic [HUE_BITS-1:0] pick_hue();
        int unsigned k;
        int unsigned border;
        if ($urandom_range(0, 7) != 0)
            return HUE_BITS'($urandom_range(0, 65535));
        // Land on or next to a sector border.
        k = $urandom_range(1, 5);
        border = (k * 65536 + 5) / 6;
        return HUE_BITS'(border + $urandom_range(0, 2) - 1);
    endfunction

    task automatic check_channel(input string field, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == CFG_SATURATION)
            sat_level = value;
        else if (index == CFG_BRIGHTNESS)
            bright_level = value;
    endtask

    task automatic set_levels(input logic [CFG_DATA_W-1:0] sat,
                              input logic [CFG_DATA_W-1:0] bright);
        write_reg(CFG_SATURATION, sat);
        write_reg(CFG_BRIGHTNESS, bright);
    endtask

    task automatic wait_drained();
        while (hue_pending.size() != 0 || rgb_awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_corners(input int first, input int count);
        for (int i = first; i < first + count; i++)
            hue_pending = {hue_pending, corner_hues[i]};
        wait_drained();
    endtask

    // Hue driver: holds a stalled beat, otherwise offers the next pending hue.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hue_valid && !hue_stall)
            begin
                rgb_awaited = {rgb_awaited,
                               expected_rgb(hue_turns, sat_level, bright_level)};
                void'(hue_pending.pop_front());
                hue_gap = idle_on ? pick_gap() : 0;
            end
            if (!hue_valid || !hue_stall)
            begin
                if (hue_gap != 0 || hue_pending.size() == 0)
                begin
                    hue_valid <= 1'b0;
                    if (hue_gap != 0)
                        hue_gap--;
                end
                else
                begin
                    hue_valid <= 1'b1;
                    hue_turns <= hue_pending[0];
                end
            end
        end
    end

    // Result monitor and output back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                results_seen++;
                if (rgb_awaited.size() == 0)
                begin
                    $error("unexpected result beat: red %0d green %0d blue %0d",
                           red, green, blue);
                    mismatches++;
                end
                else
                begin
                    check_channel("red", rgb_awaited[0].red, red);
                    check_channel("green", rgb_awaited[0].green, green);
                    check_channel("blue", rgb_awaited[0].blue, blue);
                    void'(rgb_awaited.pop_front());
                end
            end
            if (stall_left == 0 && idle_on)
                stall_left = pick_gap();
            // One long hold while the sender keeps pushing, to back the pipeline up.
            if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                stall_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            rgb_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if ((hue_valid && !hue_stall) || (rgb_valid && !rgb_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset levels, then the extremes of both registers.
        send_corners(0, 14);
        set_levels(CFG_DATA_W'(LEVEL_ONE), CFG_DATA_W'(LEVEL_ONE));
        send_corners(4, 4);
        set_levels('0, 16'hFFFF);
        send_corners(8, 3);
        set_levels(16'hFFFF, '0);
        send_corners(0, 2);
        set_levels(CFG_DATA_W'(LEVEL_ONE) + 1'b1, 16'd40000);
        send_corners(11, 3);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase % 3 != 1);
            set_levels(pick_level(), pick_level());
            for (int i = 0; i < PHASE_ITEMS; i++)
                hue_pending = {hue_pending, pick_hue()};
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
